// ----- src/dlsm_pkg.sv -----
// dlsm_pkg: types, codes and reset constants of the line-program state machine
// used by every file of the block; depends on nothing
`default_nettype none
package dlsm_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;
	localparam int ADDR_OUT_W = 64;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_INST   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_BASE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_RANGE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OP_BASE    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DEF_STMT   = 3'd4;

	localparam logic [7:0] MIN_INST_RST   = 8'd1;
	localparam logic [7:0] LINE_BASE_RST  = 8'hFB;
	localparam logic [7:0] LINE_RANGE_RST = 8'd14;
	localparam logic [7:0] OP_BASE_RST    = 8'd13;
	localparam logic       DEF_STMT_RST   = 1'b1;

	localparam logic [7:0] MAX_SPECIAL = 8'd255;

	localparam logic [1:0] KIND_STD     = 2'd0;
	localparam logic [1:0] KIND_EXT     = 2'd1;
	localparam logic [1:0] KIND_SPECIAL = 2'd2;

	localparam logic [7:0] LNS_COPY          = 8'd1;
	localparam logic [7:0] LNS_ADV_PC        = 8'd2;
	localparam logic [7:0] LNS_ADVANCE_LINE  = 8'd3;
	localparam logic [7:0] LNS_SET_FILE      = 8'd4;
	localparam logic [7:0] LNS_SET_COLUMN    = 8'd5;
	localparam logic [7:0] LNS_NEGATE_STMT   = 8'd6;
	localparam logic [7:0] LNS_SET_BLOCK     = 8'd7;
	localparam logic [7:0] LNS_CONST_ADD_PC  = 8'd8;
	localparam logic [7:0] LNS_FIXED_ADV_PC  = 8'd9;
	localparam logic [7:0] LNS_PROLOGUE_END  = 8'd10;
	localparam logic [7:0] LNS_EPILOGUE_BEG  = 8'd11;
	localparam logic [7:0] LNS_SET_ISA       = 8'd12;

	localparam logic [7:0] LNE_END_SEQ       = 8'd1;
	localparam logic [7:0] LNE_SET_ADDR      = 8'd2;
	localparam logic [7:0] LNE_DEFINE_FILE   = 8'd3;
	localparam logic [7:0] LNE_SET_DISCRIM   = 8'd4;

	typedef struct packed {
		logic [7:0] min_inst;
		logic [7:0] line_base;
		logic [7:0] line_range;
		logic [7:0] op_base;
		logic       def_stmt;
	} cfg_t;

	typedef struct packed {
		logic       start;
		logic [7:0] dividend;
		logic [7:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic       done;
		logic [7:0] quotient;
		logic [7:0] remainder;
	} div_rsp_t;

	typedef struct packed {
		logic                  row_valid;
		logic                  bad_opcode;
		logic [ADDR_OUT_W-1:0] row_address;
		logic [31:0]           row_line;
		logic [31:0]           row_column;
		logic [31:0]           row_file;
		logic                  row_is_stmt;
		logic                  row_end;
	} res_t;

endpackage
`default_nettype wire

// ----- src/dlsm_if.sv -----
// dlsm_in_if / dlsm_out_if: valid-ready channels for operations and rows
// depends on dlsm_pkg for the address width
`default_nettype none
interface dlsm_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  opcode;
	logic [63:0] argument;

	modport source(output valid, kind, opcode, argument, input ready);
	modport sink(input valid, kind, opcode, argument, output ready);
endinterface

interface dlsm_out_if;
	logic                           valid;
	logic                           ready;
	logic                           row_valid;
	logic                           bad_opcode;
	logic [dlsm_pkg::ADDR_OUT_W-1:0] row_address;
	logic [31:0]                    row_line;
	logic [31:0]                    row_column;
	logic [31:0]                    row_file;
	logic                           row_is_stmt;
	logic                           row_end;

	modport source(output valid, row_valid, bad_opcode, row_address, row_line, row_column,
		row_file, row_is_stmt, row_end, input ready);
	modport sink(input valid, row_valid, bad_opcode, row_address, row_line, row_column,
		row_file, row_is_stmt, row_end, output ready);
endinterface
`default_nettype wire

// ----- src/dlsm_div.sv -----
// dlsm_div: 8-bit restoring divider, one quotient bit per cycle
// depends on dlsm_pkg for the request and response structs
`default_nettype none
module dlsm_div (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  dlsm_pkg::div_req_t      req,
	output dlsm_pkg::div_rsp_t      rsp
);
	logic       busy_q;
	logic [2:0] cnt_q;
	logic [7:0] quo_q;
	logic [7:0] rem_q;
	logic [7:0] dsr_q;
	logic [8:0] trial;
	logic [8:0] diff;
	logic       ge;
	logic [7:0] rem_n;
	logic [7:0] quo_n;

	always_comb begin
		trial = {rem_q, quo_q[7]};
		ge    = trial >= {1'b0, dsr_q};
		diff  = trial - {1'b0, dsr_q};
		rem_n = ge ? diff[7:0] : trial[7:0];
		quo_n = {quo_q[6:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 3'd1;
			if (cnt_q == 3'd7) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= quo_n;
			rem_q <= rem_n;
		end
	end

	assign rsp.done      = busy_q && (cnt_q == 3'd7);
	assign rsp.quotient  = quo_n;
	assign rsp.remainder = rem_n;
endmodule
`default_nettype wire

// ----- src/dlsm_cfg.sv -----
// dlsm_cfg: line-program header registers behind the write port
// depends on dlsm_pkg for register indexes, reset values and cfg_t
`default_nettype none
module dlsm_cfg (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_wen,
	input  wire logic [dlsm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [dlsm_pkg::CFG_DATA_W-1:0] cfg_data,
	output dlsm_pkg::cfg_t                      cfg
);
	dlsm_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_inst   <= dlsm_pkg::MIN_INST_RST;
			cfg_q.line_base  <= dlsm_pkg::LINE_BASE_RST;
			cfg_q.line_range <= dlsm_pkg::LINE_RANGE_RST;
			cfg_q.op_base    <= dlsm_pkg::OP_BASE_RST;
			cfg_q.def_stmt   <= dlsm_pkg::DEF_STMT_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				dlsm_pkg::REG_MIN_INST:   cfg_q.min_inst   <= cfg_data;
				dlsm_pkg::REG_LINE_BASE:  cfg_q.line_base  <= cfg_data;
				dlsm_pkg::REG_LINE_RANGE: cfg_q.line_range <= cfg_data;
				dlsm_pkg::REG_OP_BASE:    cfg_q.op_base    <= cfg_data;
				dlsm_pkg::REG_DEF_STMT:   cfg_q.def_stmt   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule
`default_nettype wire

// ----- src/dwarf_line_state_machine.sv -----
// dwarf_line_state_machine: line-register sequencer around a shared divider and multiplier
// depends on dlsm_pkg, dlsm_if, dlsm_cfg and dlsm_div
//
//  channel   dir  handshake          payload
//  in_ch     in   valid/ready        kind, opcode, argument
//  out_ch    out  valid/ready        row_valid, bad_opcode, row_address .. row_end
//  cfg       in   cfg_wen            cfg_index, cfg_data
//
// plain operations go from decode straight to done; the result register is loaded in decode
// special opcodes and const_add_pc go through decode, 8 divider steps, multiply, add, done
// advance pc goes through decode, one multiply by min_inst_length, one add, done
// one operation at a time; in_ch.ready is high only while the sequencer is idle
// a row waiting on out_ch holds the next operation in its last cycle until the row transfers
// reset puts the line registers and header registers at their defaults
`default_nettype none
module dwarf_line_state_machine #(
	parameter int ADDRESS_BITS = 64
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	dlsm_in_if.sink                             in_ch,
	dlsm_out_if.source                          out_ch,
	input  wire logic                           cfg_wen,
	input  wire logic [dlsm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [dlsm_pkg::CFG_DATA_W-1:0] cfg_data
);
	localparam int AW     = ADDRESS_BITS;
	localparam int OUT_AW = dlsm_pkg::ADDR_OUT_W;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_DIV    = 3'd2;
	localparam logic [2:0] S_MUL    = 3'd3;
	localparam logic [2:0] S_ADD    = 3'd4;
	localparam logic [2:0] S_DONE   = 3'd5;

	dlsm_pkg::cfg_t     cfg;
	dlsm_pkg::div_req_t div_req;
	dlsm_pkg::div_rsp_t div_rsp;

	logic [2:0]    state_q;
	logic [1:0]    kind_q;
	logic [7:0]    opcode_q;
	logic [63:0]   arg_q;
	logic [AW-1:0] addr_q;
	logic [31:0]   line_q;
	logic [31:0]   col_q;
	logic [31:0]   file_q;
	logic          stmt_q;
	logic          block_q;
	logic          prologue_q;
	logic          epilogue_q;
	logic [31:0]   isa_q;
	logic [31:0]   discr_q;
	logic          special_q;
	logic [AW-1:0] mul_a_q;
	logic [7:0]    rem_q;
	logic [AW-1:0] prod_q;
	dlsm_pkg::res_t res_q;
	dlsm_pkg::res_t out_q;
	logic          out_valid_q;

	logic            is_special_ok;
	logic            is_const_add;
	logic            is_adv_pc;
	logic [AW+7:0]   mul_full;
	logic [AW-1:0]   addr_n;
	logic [31:0]     line_adv;
	logic [31:0]     line_n;
	dlsm_pkg::res_t  res_dec;

	dlsm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	dlsm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_comb begin
		is_special_ok = (kind_q == dlsm_pkg::KIND_SPECIAL) && (opcode_q >= cfg.op_base);
		is_const_add  = (kind_q == dlsm_pkg::KIND_STD) && (opcode_q == dlsm_pkg::LNS_CONST_ADD_PC);
		is_adv_pc     = (kind_q == dlsm_pkg::KIND_STD) && (opcode_q == dlsm_pkg::LNS_ADV_PC);
		div_req.start    = (state_q == S_DECODE) && (is_special_ok || is_const_add);
		div_req.dividend = (kind_q == dlsm_pkg::KIND_SPECIAL) ? (opcode_q - cfg.op_base)
			: (dlsm_pkg::MAX_SPECIAL - cfg.op_base);
		div_req.divisor  = cfg.line_range;
		mul_full = (AW+8)'(mul_a_q) * (AW+8)'(cfg.min_inst);
		addr_n   = addr_q + prod_q;
		line_adv = (cfg.line_range == 8'd0) ? 32'd0
			: ({{24{cfg.line_base[7]}}, cfg.line_base} + {24'd0, rem_q});
		line_n   = line_q + line_adv;
	end

	// result fields known at decode
	always_comb begin
		res_dec = '0;
		case (kind_q)
			dlsm_pkg::KIND_STD: begin
				if (opcode_q == dlsm_pkg::LNS_COPY) begin
					res_dec.row_valid   = 1'b1;
					res_dec.row_address = OUT_AW'(addr_q);
					res_dec.row_line    = line_q;
					res_dec.row_column  = col_q;
					res_dec.row_file    = file_q;
					res_dec.row_is_stmt = stmt_q;
				end else if (opcode_q == 8'd0 || opcode_q > dlsm_pkg::LNS_SET_ISA) begin
					res_dec.bad_opcode = 1'b1;
				end
			end
			dlsm_pkg::KIND_EXT: begin
				if (opcode_q == dlsm_pkg::LNE_END_SEQ) begin
					res_dec.row_valid   = 1'b1;
					res_dec.row_address = OUT_AW'(addr_q);
					res_dec.row_is_stmt = stmt_q;
					res_dec.row_end     = 1'b1;
				end else if (opcode_q == 8'd0 || opcode_q > dlsm_pkg::LNE_SET_DISCRIM) begin
					res_dec.bad_opcode = 1'b1;
				end
			end
			dlsm_pkg::KIND_SPECIAL: res_dec.bad_opcode = !is_special_ok;
			default: res_dec.bad_opcode = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			addr_q      <= '0;
			line_q      <= 32'd1;
			col_q       <= '0;
			file_q      <= 32'd1;
			stmt_q      <= dlsm_pkg::DEF_STMT_RST;
			block_q     <= 1'b0;
			prologue_q  <= 1'b0;
			epilogue_q  <= 1'b0;
			isa_q       <= '0;
			discr_q     <= '0;
		end else begin
			if (state_q == S_DONE && (!out_valid_q || out_ch.ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					if (is_special_ok || is_const_add) begin
						state_q <= S_DIV;
					end else if (is_adv_pc) begin
						state_q <= S_MUL;
					end else begin
						state_q <= S_DONE;
					end
					case (kind_q)
						dlsm_pkg::KIND_STD: begin
							case (opcode_q)
								dlsm_pkg::LNS_COPY: begin
									block_q    <= 1'b0;
									prologue_q <= 1'b0;
									epilogue_q <= 1'b0;
									discr_q    <= '0;
								end
								dlsm_pkg::LNS_ADVANCE_LINE: line_q <= line_q + arg_q[31:0];
								dlsm_pkg::LNS_SET_FILE:     file_q <= arg_q[31:0];
								dlsm_pkg::LNS_SET_COLUMN:   col_q <= arg_q[31:0];
								dlsm_pkg::LNS_NEGATE_STMT:  stmt_q <= !stmt_q;
								dlsm_pkg::LNS_SET_BLOCK:    block_q <= 1'b1;
								dlsm_pkg::LNS_FIXED_ADV_PC: addr_q <= addr_q + AW'(arg_q[15:0]);
								dlsm_pkg::LNS_PROLOGUE_END: prologue_q <= 1'b1;
								dlsm_pkg::LNS_EPILOGUE_BEG: epilogue_q <= 1'b1;
								dlsm_pkg::LNS_SET_ISA:      isa_q <= arg_q[31:0];
								default: ;
							endcase
						end
						dlsm_pkg::KIND_EXT: begin
							case (opcode_q)
								dlsm_pkg::LNE_END_SEQ: begin
									addr_q     <= '0;
									line_q     <= 32'd1;
									col_q      <= '0;
									file_q     <= 32'd1;
									stmt_q     <= cfg.def_stmt;
									block_q    <= 1'b0;
									prologue_q <= 1'b0;
									epilogue_q <= 1'b0;
									isa_q      <= '0;
									discr_q    <= '0;
								end
								dlsm_pkg::LNE_SET_ADDR:    addr_q <= arg_q[AW-1:0];
								dlsm_pkg::LNE_SET_DISCRIM: discr_q <= arg_q[31:0];
								default: ;
							endcase
						end
						default: ;
					endcase
				end
				S_DIV: begin
					if (div_rsp.done) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: state_q <= S_ADD;
				S_ADD: begin
					state_q <= S_DONE;
					addr_q  <= addr_n;
					if (special_q) begin
						line_q     <= line_n;
						block_q    <= 1'b0;
						prologue_q <= 1'b0;
						epilogue_q <= 1'b0;
						discr_q    <= '0;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ch.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// operation payload, arithmetic operands and result rows
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				kind_q   <= in_ch.kind;
				opcode_q <= in_ch.opcode;
				arg_q    <= in_ch.argument;
			end
			S_DECODE: begin
				res_q     <= res_dec;
				special_q <= is_special_ok;
				mul_a_q   <= arg_q[AW-1:0];
			end
			S_DIV: begin
				mul_a_q <= (cfg.line_range == 8'd0) ? '0 : AW'(div_rsp.quotient);
				rem_q   <= div_rsp.remainder;
			end
			S_MUL: prod_q <= mul_full[AW-1:0];
			S_ADD: begin
				if (special_q) begin
					res_q.row_valid   <= 1'b1;
					res_q.row_address <= OUT_AW'(addr_n);
					res_q.row_line    <= line_n;
					res_q.row_column  <= col_q;
					res_q.row_file    <= file_q;
					res_q.row_is_stmt <= stmt_q;
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ch.ready) begin
					out_q <= res_q;
				end
			end
			default: ;
		endcase
	end

	assign in_ch.ready        = (state_q == S_IDLE);
	assign out_ch.valid       = out_valid_q;
	assign out_ch.row_valid   = out_q.row_valid;
	assign out_ch.bad_opcode  = out_q.bad_opcode;
	assign out_ch.row_address = out_q.row_address;
	assign out_ch.row_line    = out_q.row_line;
	assign out_ch.row_column  = out_q.row_column;
	assign out_ch.row_file    = out_q.row_file;
	assign out_ch.row_is_stmt = out_q.row_is_stmt;
	assign out_ch.row_end     = out_q.row_end;
endmodule
`default_nettype wire

// ----- src/dlsm_chk.sv -----
// dlsm_chk: port-level checks on the line-program state machine, bound to the top level
// depends on dlsm_pkg and dwarf_line_state_machine
`default_nettype none
module dlsm_chk (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            in_valid,
	input wire logic                            in_ready,
	input wire logic                            out_valid,
	input wire logic                            out_ready,
	input wire logic                            row_valid,
	input wire logic                            bad_opcode,
	input wire logic [dlsm_pkg::ADDR_OUT_W-1:0] row_address,
	input wire logic [31:0]                     row_line,
	input wire logic [31:0]                     row_column,
	input wire logic [31:0]                     row_file,
	input wire logic                            row_end
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready held after operation transfer");

	a_bad_no_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_opcode |-> !row_valid && row_address == '0 && !row_end)
		else $error("bad opcode with row contents");

	a_end_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && row_end |-> row_valid && row_line == 32'd0 && row_column == 32'd0
		&& row_file == 32'd0)
		else $error("closing row with nonzero line, column or file");
endmodule

bind dwarf_line_state_machine dlsm_chk u_dlsm_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_ch.valid),
	.in_ready    (in_ch.ready),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.row_valid   (out_ch.row_valid),
	.bad_opcode  (out_ch.bad_opcode),
	.row_address (out_ch.row_address),
	.row_line    (out_ch.row_line),
	.row_column  (out_ch.row_column),
	.row_file    (out_ch.row_file),
	.row_end     (out_ch.row_end)
);
`default_nettype wire

// ----- bench/dlsm_row_checker.sv -----
`timescale 1ns / 1ps
// dlsm_row_checker: watches the operation and row channels of the line state machine,
// predicts every row from its own copy of the line and header registers and compares
// depends on dlsm_pkg and the channel interfaces in dlsm_if
module dlsm_row_checker
	import dlsm_pkg::*;
#(
	parameter int ADDRESS_BITS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	dlsm_in_if                    op_ch,
	dlsm_out_if                   row_ch,
	input  logic                  cfg_wen,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    fail_count,
	output int                    rows_pending
);

	localparam logic [63:0] ADDR_MASK = {64{1'b1}} >> (64 - ADDRESS_BITS);

	cfg_t        hdr;
	logic [63:0] cur_address;
	logic [31:0] cur_line;
	logic [31:0] cur_column;
	logic [31:0] cur_file;
	logic        stmt_flag;
	logic        block_flag;
	logic        prologue_flag;
	logic        epilogue_flag;
	logic [31:0] cur_isa;
	logic [31:0] cur_discriminator;
	res_t        rows_due[$];

	function automatic void load_defaults();
		cur_address = '0;
		cur_line = 32'd1;
		cur_column = '0;
		cur_file = 32'd1;
		stmt_flag = hdr.def_stmt;
		block_flag = 1'b0;
		prologue_flag = 1'b0;
		epilogue_flag = 1'b0;
		cur_isa = '0;
		cur_discriminator = '0;
	endfunction

	function automatic void clear_row_flags();
		block_flag = 1'b0;
		prologue_flag = 1'b0;
		epilogue_flag = 1'b0;
		cur_discriminator = '0;
	endfunction

	function automatic res_t emit_row(input logic [63:0] addr, input logic [31:0] line,
			input logic [31:0] col, input logic [31:0] file, input logic stmt,
			input logic closing);
		res_t r;
		r = '0;
		r.row_valid = 1'b1;
		r.row_address = addr & ADDR_MASK;
		r.row_line = line;
		r.row_column = col;
		r.row_file = file;
		r.row_is_stmt = stmt;
		r.row_end = closing;
		return r;
	endfunction

	function automatic logic [63:0] special_addr_step(input logic [7:0] op);
		logic [7:0] adj;
		adj = op - hdr.op_base;
		if (hdr.line_range == 8'd0)
			return '0;
		return {56'd0, adj / hdr.line_range} * {56'd0, hdr.min_inst};
	endfunction

	function automatic res_t predict_row(input logic [1:0] kind, input logic [7:0] op,
			input logic [63:0] arg);
		res_t       r;
		logic [7:0] adj;
		r = '0;
		case (kind)
		KIND_STD: case (op)
			LNS_COPY: begin
				r = emit_row(cur_address, cur_line, cur_column, cur_file, stmt_flag, 1'b0);
				clear_row_flags();
			end
			LNS_ADV_PC: cur_address = (cur_address + arg * {56'd0, hdr.min_inst}) & ADDR_MASK;
			LNS_ADVANCE_LINE: cur_line = cur_line + arg[31:0];
			LNS_SET_FILE: cur_file = arg[31:0];
			LNS_SET_COLUMN: cur_column = arg[31:0];
			LNS_NEGATE_STMT: stmt_flag = !stmt_flag;
			LNS_SET_BLOCK: block_flag = 1'b1;
			LNS_CONST_ADD_PC:
				cur_address = (cur_address + special_addr_step(MAX_SPECIAL)) & ADDR_MASK;
			LNS_FIXED_ADV_PC: cur_address = (cur_address + {48'd0, arg[15:0]}) & ADDR_MASK;
			LNS_PROLOGUE_END: prologue_flag = 1'b1;
			LNS_EPILOGUE_BEG: epilogue_flag = 1'b1;
			LNS_SET_ISA: cur_isa = arg[31:0];
			default: r.bad_opcode = 1'b1;
		endcase
		KIND_EXT: case (op)
			LNE_END_SEQ: begin
				r = emit_row(cur_address, '0, '0, '0, stmt_flag, 1'b1);
				load_defaults();
			end
			LNE_SET_ADDR: cur_address = arg & ADDR_MASK;
			LNE_DEFINE_FILE: ;
			LNE_SET_DISCRIM: cur_discriminator = arg[31:0];
			default: r.bad_opcode = 1'b1;
		endcase
		KIND_SPECIAL: begin
			if (op < hdr.op_base) begin
				r.bad_opcode = 1'b1;
			end else begin
				adj = op - hdr.op_base;
				cur_address = (cur_address + special_addr_step(op)) & ADDR_MASK;
				if (hdr.line_range != 8'd0)
					cur_line = cur_line + {{24{hdr.line_base[7]}}, hdr.line_base}
						+ {24'd0, adj % hdr.line_range};
				r = emit_row(cur_address, cur_line, cur_column, cur_file, stmt_flag, 1'b0);
				clear_row_flags();
			end
		end
		default: r.bad_opcode = 1'b1;
		endcase
		return r;
	endfunction

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		res_t got;
		if (!arst_n) begin
			hdr = '{min_inst: MIN_INST_RST, line_base: LINE_BASE_RST,
				line_range: LINE_RANGE_RST, op_base: OP_BASE_RST, def_stmt: DEF_STMT_RST};
			load_defaults();
			rows_due.delete();
		end else begin
			if (cfg_wen) begin
				case (cfg_index)
				REG_MIN_INST: hdr.min_inst = cfg_data;
				REG_LINE_BASE: hdr.line_base = cfg_data;
				REG_LINE_RANGE: hdr.line_range = cfg_data;
				REG_OP_BASE: hdr.op_base = cfg_data;
				REG_DEF_STMT: hdr.def_stmt = cfg_data[0];
				default: ;
				endcase
			end
			if (row_ch.valid && row_ch.ready) begin
				got = '{row_valid: row_ch.row_valid, bad_opcode: row_ch.bad_opcode,
					row_address: row_ch.row_address, row_line: row_ch.row_line,
					row_column: row_ch.row_column, row_file: row_ch.row_file,
					row_is_stmt: row_ch.row_is_stmt, row_end: row_ch.row_end};
				if (rows_due.size() == 0) begin
					fail_count++;
					$display("%0t: row transfer with no operation waiting, actual %h", $time, got);
				end else begin
					want = rows_due.pop_front();
					check_field("row_valid", want.row_valid, got.row_valid);
					check_field("bad_opcode", want.bad_opcode, got.bad_opcode);
					check_field("row_address", want.row_address, got.row_address);
					check_field("row_line", want.row_line, got.row_line);
					check_field("row_column", want.row_column, got.row_column);
					check_field("row_file", want.row_file, got.row_file);
					check_field("row_is_stmt", want.row_is_stmt, got.row_is_stmt);
					check_field("row_end", want.row_end, got.row_end);
				end
			end
			if (op_ch.valid && op_ch.ready)
				rows_due.push_back(predict_row(op_ch.kind, op_ch.opcode, op_ch.argument));
		end
		rows_pending = rows_due.size();
	end

endmodule

// ----- bench/dwarf_line_state_machine_tb.sv -----
`timescale 1ns / 1ps
// dwarf_line_state_machine_tb: drives line programs and header settings into the block
// and gives the verdict; rows are predicted and compared in dlsm_row_checker
// depends on dlsm_pkg, dlsm_if, dlsm_row_checker and the block itself
module dwarf_line_state_machine_tb;
	import dlsm_pkg::*;

	localparam int         CYCLE_LIMIT = 400000;
	localparam int         PHASES      = 8;
	localparam int         PHASE_OPS   = 48;
	localparam logic [7:0] OP_NONE     = 8'd0;
	localparam logic [7:0] OP_TOP      = 8'hFF;
	localparam logic [1:0] KIND_BAD    = 2'd3;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wen;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    fail_count;
	int                    rows_pending;
	int                    cycle_count;
	int                    ops_sent;
	bit                    tx_steady;
	bit                    rx_steady;
	logic [7:0]            cur_op_base;

	dlsm_in_if  op_ch();
	dlsm_out_if row_ch();

	dwarf_line_state_machine DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (op_ch),
		.out_ch    (row_ch),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	dlsm_row_checker row_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.op_ch        (op_ch),
		.row_ch       (row_ch),
		.cfg_wen      (cfg_wen),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.rows_pending (rows_pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	// row sink with random stalls
	initial begin
		int stall;
		row_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = rx_steady ? 0 : $urandom_range(0, 19);
			if (stall != 0) begin
				row_ch.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			row_ch.ready = 1'b1;
			do @(posedge clk); while (!row_ch.valid);
		end
	end

	task automatic send_op(input logic [1:0] kind, input logic [7:0] opcode,
			input logic [63:0] argument);
		int gap;
		gap = tx_steady ? 0 : $urandom_range(0, 19);
		if (gap != 0) begin
			op_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		op_ch.valid = 1'b1;
		op_ch.kind = kind;
		op_ch.opcode = opcode;
		op_ch.argument = argument;
		do @(posedge clk); while (!op_ch.ready);
		@(negedge clk);
		ops_sent++;
	endtask

	task automatic drain_rows();
		op_ch.valid = 1'b0;
		while (rows_pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
		cfg_wen = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_wen = 1'b0;
	endtask

	task automatic set_header(input logic [7:0] min_inst, input logic [7:0] line_base,
			input logic [7:0] line_range, input logic [7:0] op_base, input logic def_stmt);
		write_reg(REG_MIN_INST, min_inst);
		write_reg(REG_LINE_BASE, line_base);
		write_reg(REG_LINE_RANGE, line_range);
		write_reg(REG_OP_BASE, op_base);
		write_reg(REG_DEF_STMT, {7'($urandom), def_stmt});
		cur_op_base = op_base;
	endtask

	function automatic logic [63:0] any_arg();
		return $urandom_range(0, 1) ? {$urandom, $urandom} : 64'($urandom_range(0, 300));
	endfunction

	task automatic random_op();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 40)
			send_op(KIND_SPECIAL, ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255))
				: 8'($urandom_range(cur_op_base, 255)), {$urandom, $urandom});
		else if (pick < 48) send_op(KIND_STD, LNS_COPY, {$urandom, $urandom});
		else if (pick < 54) send_op(KIND_STD, LNS_ADV_PC, any_arg());
		else if (pick < 62)
			send_op(KIND_STD, LNS_ADVANCE_LINE,
				{$urandom, 32'($urandom_range(0, 80)) - 32'd40});
		else if (pick < 66) send_op(KIND_STD, LNS_SET_FILE, any_arg());
		else if (pick < 70) send_op(KIND_STD, LNS_SET_COLUMN, any_arg());
		else if (pick < 74) send_op(KIND_STD, LNS_NEGATE_STMT, {$urandom, $urandom});
		else if (pick < 77) send_op(KIND_STD, LNS_SET_BLOCK, {$urandom, $urandom});
		else if (pick < 81) send_op(KIND_STD, LNS_CONST_ADD_PC, {$urandom, $urandom});
		else if (pick < 85) send_op(KIND_STD, LNS_FIXED_ADV_PC, any_arg());
		else if (pick < 87) send_op(KIND_STD, LNS_PROLOGUE_END, {$urandom, $urandom});
		else if (pick < 89) send_op(KIND_STD, LNS_EPILOGUE_BEG, {$urandom, $urandom});
		else if (pick < 91) send_op(KIND_STD, LNS_SET_ISA, any_arg());
		else if (pick < 93) send_op(KIND_EXT, LNE_SET_DISCRIM, any_arg());
		else if (pick < 94) send_op(KIND_EXT, LNE_DEFINE_FILE, {$urandom, $urandom});
		else if (pick < 95) send_op(KIND_EXT, LNE_SET_ADDR, {$urandom, $urandom});
		else
			send_op(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), {$urandom, $urandom});
	endtask

	// new address, a run of operations, then usually a closing row
	task automatic run_sequence();
		int n;
		tx_steady = ($urandom_range(0, 3) == 0);
		rx_steady = ($urandom_range(0, 3) == 0);
		n = $urandom_range(3, 14);
		send_op(KIND_EXT, LNE_SET_ADDR, any_arg());
		repeat (n) random_op();
		if ($urandom_range(0, 9) != 0)
			send_op(KIND_EXT, LNE_END_SEQ, {$urandom, $urandom});
	endtask

	initial begin
		int start_ops;
		op_ch.valid = 1'b0;
		op_ch.kind = KIND_STD;
		op_ch.opcode = OP_NONE;
		op_ch.argument = '0;
		cfg_wen = 1'b0;
		cfg_index = REG_MIN_INST;
		cfg_data = '0;
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		ops_sent = 0;
		cur_op_base = OP_BASE_RST;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// every operation and the field extremes under the reset header
		send_op(KIND_STD, LNS_COPY, '0);
		send_op(KIND_STD, LNS_ADV_PC, '1);
		send_op(KIND_STD, LNS_ADVANCE_LINE, {32'hFFFF_FFFF, 32'h8000_0000});
		send_op(KIND_STD, LNS_SET_FILE, '1);
		send_op(KIND_STD, LNS_SET_COLUMN, {32'hFFFF_FFFF, 32'd0});
		send_op(KIND_SPECIAL, MAX_SPECIAL, '0);
		send_op(KIND_STD, LNS_NEGATE_STMT, '0);
		send_op(KIND_STD, LNS_SET_BLOCK, '1);
		send_op(KIND_STD, LNS_CONST_ADD_PC, '0);
		send_op(KIND_STD, LNS_FIXED_ADV_PC, '1);
		send_op(KIND_STD, LNS_PROLOGUE_END, '0);
		send_op(KIND_STD, LNS_EPILOGUE_BEG, '0);
		send_op(KIND_STD, LNS_SET_ISA, '1);
		send_op(KIND_EXT, LNE_SET_DISCRIM, '1);
		send_op(KIND_STD, LNS_COPY, '1);
		send_op(KIND_EXT, LNE_DEFINE_FILE, '1);
		send_op(KIND_SPECIAL, OP_BASE_RST, '0);
		send_op(KIND_SPECIAL, OP_BASE_RST - 8'd1, '1);
		send_op(KIND_STD, OP_NONE, '1);
		send_op(KIND_STD, LNS_SET_ISA + 8'd1, '0);
		send_op(KIND_EXT, LNE_SET_DISCRIM + 8'd1, '0);
		send_op(KIND_EXT, OP_TOP, '1);
		send_op(KIND_BAD, LNS_COPY, '1);
		send_op(KIND_EXT, LNE_SET_ADDR, '1);
		send_op(KIND_SPECIAL, MAX_SPECIAL, '1);
		send_op(KIND_EXT, LNE_END_SEQ, '0);
		drain_rows();

		for (int p = 0; p < PHASES; p++) begin
			case (p)
			0: set_header(8'd255, 8'h80, 8'd1, 8'd1, 1'b0);
			1: set_header(8'd1, 8'h7F, 8'd255, 8'd255, 1'b1);
			2: set_header(8'($urandom_range(1, 255)), 8'($urandom), 8'd0, OP_BASE_RST,
				1'($urandom));
			3: set_header(8'($urandom_range(1, 255)), 8'($urandom), 8'($urandom_range(1, 255)),
				OP_NONE, 1'($urandom));
			default: set_header(8'($urandom_range(1, 255)), 8'($urandom),
				8'($urandom_range(1, 255)), 8'($urandom_range(1, 40)), 1'($urandom));
			endcase
			if (p == 5)
				write_reg(CFG_IDX_W'(REG_DEF_STMT + $urandom_range(1, 3)), 8'($urandom));
			start_ops = ops_sent;
			while (ops_sent - start_ops < PHASE_OPS)
				run_sequence();
			drain_rows();
		end

		if (fail_count == 0 && rows_pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ----- filelist.f -----
src/dlsm_pkg.sv
src/dlsm_if.sv
src/dlsm_div.sv
src/dlsm_cfg.sv
src/dwarf_line_state_machine.sv
src/dlsm_chk.sv
bench/dlsm_row_checker.sv
bench/dwarf_line_state_machine_tb.sv
